// ===== rtl/i2c_bus_master_sequencer_macros.svh =====
// assertion macros for the i2c bus master sequencer
// used by the top level only, expects clk and rst in scope
`ifndef I2C_BUS_MASTER_SEQUENCER_MACROS_SVH
`define I2C_BUS_MASTER_SEQUENCER_MACROS_SVH

// condition holds in the same cycle
`define I2CBM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define I2CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cbm_pkg.sv =====
// shared types and constants of the i2c bus master sequencer
// no dependencies
package i2cbm_pkg;

  localparam int BITS_PER_BYTE_DEF = 8;
  localparam int CNT_W             = 4;
  localparam logic [7:0] ACK_WAIT_RESET = 8'd250;

  // command classes handed from front to back
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_START = 3'd1;
  localparam logic [2:0] CLS_STOP  = 3'd2;
  localparam logic [2:0] CLS_WRITE = 3'd3;
  localparam logic [2:0] CLS_WACK  = 3'd4;
  localparam logic [2:0] CLS_READ  = 3'd5;

  // what follows the data bits of a read
  localparam logic [1:0] TAIL_ACK  = 2'd0;
  localparam logic [1:0] TAIL_NACK = 2'd1;
  localparam logic [1:0] TAIL_NONE = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_timeout;
  } out_word_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [1:0] tail;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_word_t;

  typedef struct packed {
    logic      valid;
    cmd_word_t word;
  } cmd_t;

endpackage

// ===== rtl/i2c_bus_master_sequencer.sv =====
// top level of the i2c bus master sequencer: front decode queue and back sequencer
// depends on i2cbm_pkg, i2cbm_front, i2cbm_back and the macros header
//
//   channel   handshake        payload
//   input     push / full      item_in    (in_word_t)
//   result    empty / pop      result_out (out_word_t)
//   config    cfg_write        cfg_data   (ack wait limit)
//
// one word in, one word out; a pushed word is registered in the decode queue, then the
// sequencer step writes its result into the result queue, which drops empty
// sustained rate is one word per cycle while results are popped, set by the single sequencer step per cycle
// both queues hold two words, so a stalled pop backs up into full after four words
// rst is synchronous; after it the line registers are high with sda driven and both queues are empty
`include "i2c_bus_master_sequencer_macros.svh"

module i2c_bus_master_sequencer
  import i2cbm_pkg::*;
#(
  parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  item_in,
  output logic      empty,
  input  logic      pop,
  output out_word_t result_out,
  input  logic      cfg_write,
  input  logic [7:0] cfg_data
);

  cmd_t cmd;
  logic take;

  // decode and queue
  i2cbm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item_in (item_in),
    .cmd     (cmd),
    .take    (take)
  );

  // sequencer and result queue
  i2cbm_back #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .result_out (result_out)
  );

  // checks
  `I2CBM_ASSERT_SAME(a_take_valid, take, cmd.valid, "sequencer took from an empty queue")
  `I2CBM_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty, "waiting result word was lost")
  `I2CBM_ASSERT_SAME(a_done_idle, !empty && result_out.done_res, !result_out.busy_res, "done while busy")

endmodule

// ===== rtl/i2cbm_front.sv =====
// front end: accepts words, decodes the operation and queues them
// depends on i2cbm_pkg
module i2cbm_front
  import i2cbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_word_t item_in,
  output cmd_t     cmd,
  input  logic     take
);

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WACK  = 3'd4;
  localparam logic [2:0] OP_RACK  = 3'd5;
  localparam logic [2:0] OP_RNACK = 3'd6;
  localparam logic [2:0] OP_RONLY = 3'd7;

  cmd_word_t  dec;
  cmd_word_t  q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       take_ok;

  // operation decode
  always_comb begin
    dec.write_data = item_in.write_data;
    dec.sda_in     = item_in.sda_in;
    dec.tail       = TAIL_NONE;
    unique case (item_in.operation)
      OP_NONE:  dec.cls = CLS_NONE;
      OP_START: dec.cls = CLS_START;
      OP_STOP:  dec.cls = CLS_STOP;
      OP_WRITE: dec.cls = CLS_WRITE;
      OP_WACK:  dec.cls = CLS_WACK;
      OP_RACK: begin
        dec.cls  = CLS_READ;
        dec.tail = TAIL_ACK;
      end
      OP_RNACK: begin
        dec.cls  = CLS_READ;
        dec.tail = TAIL_NACK;
      end
      OP_RONLY: dec.cls = CLS_READ;
      default:  dec.cls = CLS_NONE;
    endcase
  end

  assign full    = (count == 2'd2);
  assign push_ok = push && !full;
  assign take_ok = take && (count != 2'd0);

  assign cmd.valid = (count != 2'd0);
  assign cmd.word  = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= dec;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (take_ok) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push_ok} - {1'b0, take_ok};
    end
  end

endmodule

// ===== rtl/i2cbm_back.sv =====
// back end: line sequencer, one phase per word, and the result queue
// depends on i2cbm_pkg
module i2cbm_back
  import i2cbm_pkg::*;
#(
  parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic [7:0] cfg_data,
  input  cmd_t      cmd,
  output logic      take,
  output logic      empty,
  input  logic      pop,
  output out_word_t result_out
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_ST1    = 4'd1;
  localparam logic [3:0] PH_ST2    = 4'd2;
  localparam logic [3:0] PH_SP1    = 4'd3;
  localparam logic [3:0] PH_SP2    = 4'd4;
  localparam logic [3:0] PH_SP3    = 4'd5;
  localparam logic [3:0] PH_WA1    = 4'd6;
  localparam logic [3:0] PH_WAP    = 4'd7;
  localparam logic [3:0] PH_WB_HI  = 4'd8;
  localparam logic [3:0] PH_WB_LO  = 4'd9;
  localparam logic [3:0] PH_WB_SET = 4'd10;
  localparam logic [3:0] PH_RD_HI  = 4'd11;
  localparam logic [3:0] PH_RD_LO  = 4'd12;
  localparam logic [3:0] PH_RA_SET = 4'd13;
  localparam logic [3:0] PH_RA_HI  = 4'd14;
  localparam logic [3:0] PH_RA_LO  = 4'd15;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BITS_PER_BYTE - 1);

  logic [7:0]       ack_wait_limit;
  logic [3:0]       phase, phase_next;
  logic [1:0]       tail, tail_next;
  logic [CNT_W-1:0] bit_counter, bit_counter_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [7:0]       wait_counter, wait_counter_next;
  logic             scl_reg, scl_reg_next;
  logic             sda_reg, sda_reg_next;
  logic             drive_reg, drive_reg_next;
  logic             timeout_flag, timeout_flag_next;
  logic [7:0]       read_hold, read_hold_next;
  logic             done;
  logic             last_bit;
  logic [8:0]       wait_inc;
  logic [7:0]       rd_shift;
  cmd_word_t        cw;
  out_word_t        res;

  out_word_t  oq [2];
  logic       owr_ptr;
  logic       ord_ptr;
  logic [1:0] ocount;
  logic       pop_ok;

  assign cw       = cmd.word;
  assign last_bit = (bit_counter == LAST_IDX);
  assign wait_inc = {1'b0, wait_counter} + 9'd1;
  assign rd_shift = {shift_byte[6:0], cw.sda_in};

  // result queue handshake
  assign empty  = (ocount == 2'd0);
  assign pop_ok = pop && !empty;
  assign take   = cmd.valid && ((ocount != 2'd2) || pop_ok);
  assign result_out = oq[ord_ptr];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit <= ACK_WAIT_RESET;
    end else if (cfg_write) begin
      ack_wait_limit <= cfg_data;
    end
  end

  // next phase and line levels
  always_comb begin
    phase_next        = phase;
    tail_next         = tail;
    bit_counter_next  = bit_counter;
    shift_byte_next   = shift_byte;
    wait_counter_next = wait_counter;
    scl_reg_next      = scl_reg;
    sda_reg_next      = sda_reg;
    drive_reg_next    = drive_reg;
    timeout_flag_next = timeout_flag;
    read_hold_next    = read_hold;
    done              = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        unique case (cw.cls)
          CLS_START: begin
            drive_reg_next = 1'b1;
            scl_reg_next   = 1'b1;
            sda_reg_next   = 1'b1;
            phase_next     = PH_ST1;
          end
          CLS_STOP: begin
            drive_reg_next = 1'b1;
            scl_reg_next   = 1'b0;
            sda_reg_next   = 1'b0;
            phase_next     = PH_SP1;
          end
          CLS_WRITE: begin
            bit_counter_next = '0;
            drive_reg_next   = 1'b1;
            scl_reg_next     = 1'b0;
            sda_reg_next     = cw.write_data[7];
            shift_byte_next  = {cw.write_data[6:0], 1'b0};
            phase_next       = PH_WB_HI;
          end
          CLS_WACK: begin
            drive_reg_next    = 1'b0;
            sda_reg_next      = 1'b1;
            timeout_flag_next = 1'b0;
            wait_counter_next = '0;
            phase_next        = PH_WA1;
          end
          CLS_READ: begin
            tail_next        = cw.tail;
            shift_byte_next  = '0;
            bit_counter_next = '0;
            drive_reg_next   = 1'b0;
            scl_reg_next     = 1'b0;
            phase_next       = PH_RD_HI;
          end
          default: begin
          end
        endcase
      end
      PH_ST1: begin
        sda_reg_next = 1'b0;
        phase_next   = PH_ST2;
      end
      PH_ST2: begin
        scl_reg_next = 1'b0;
        done         = 1'b1;
      end
      PH_SP1: phase_next = PH_SP2;
      PH_SP2: begin
        scl_reg_next = 1'b1;
        sda_reg_next = 1'b1;
        phase_next   = PH_SP3;
      end
      PH_SP3: done = 1'b1;
      PH_WA1: begin
        scl_reg_next = 1'b1;
        phase_next   = PH_WAP;
      end
      // poll for ack, stop on timeout
      PH_WAP: begin
        if (!cw.sda_in) begin
          scl_reg_next = 1'b0;
          done         = 1'b1;
        end else if (wait_inc > {1'b0, ack_wait_limit}) begin
          timeout_flag_next = 1'b1;
          drive_reg_next    = 1'b1;
          scl_reg_next      = 1'b0;
          sda_reg_next      = 1'b0;
          phase_next        = PH_SP1;
        end else begin
          wait_counter_next = wait_inc[7:0];
        end
      end
      PH_WB_HI: begin
        scl_reg_next = 1'b1;
        phase_next   = PH_WB_LO;
      end
      PH_WB_LO: begin
        scl_reg_next = 1'b0;
        if (last_bit) begin
          done = 1'b1;
        end else begin
          bit_counter_next = bit_counter + 1'b1;
          phase_next       = PH_WB_SET;
        end
      end
      PH_WB_SET: begin
        sda_reg_next    = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        phase_next      = PH_WB_HI;
      end
      // sample one data bit on the high clock
      PH_RD_HI: begin
        scl_reg_next    = 1'b1;
        shift_byte_next = rd_shift;
        if (last_bit) begin
          if (tail == TAIL_NONE) begin
            read_hold_next = rd_shift;
            done           = 1'b1;
          end else begin
            phase_next = PH_RA_SET;
          end
        end else begin
          bit_counter_next = bit_counter + 1'b1;
          phase_next       = PH_RD_LO;
        end
      end
      PH_RD_LO: begin
        scl_reg_next = 1'b0;
        phase_next   = PH_RD_HI;
      end
      PH_RA_SET: begin
        drive_reg_next = 1'b1;
        scl_reg_next   = 1'b0;
        sda_reg_next   = (tail != TAIL_ACK);
        phase_next     = PH_RA_HI;
      end
      PH_RA_HI: begin
        scl_reg_next = 1'b1;
        phase_next   = PH_RA_LO;
      end
      PH_RA_LO: begin
        scl_reg_next   = 1'b0;
        read_hold_next = shift_byte;
        done           = 1'b1;
      end
      default: phase_next = PH_IDLE;
    endcase
    if (done) begin
      phase_next = PH_IDLE;
    end
  end

  // result word for this tick
  always_comb begin
    res.scl_level   = scl_reg_next;
    res.sda_level   = sda_reg_next;
    res.sda_drive   = drive_reg_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.read_data   = read_hold_next;
    res.ack_timeout = timeout_flag_next;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tail         <= TAIL_ACK;
      bit_counter  <= '0;
      shift_byte   <= '0;
      wait_counter <= '0;
      scl_reg      <= 1'b1;
      sda_reg      <= 1'b1;
      drive_reg    <= 1'b1;
      timeout_flag <= 1'b0;
      read_hold    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      tail         <= tail_next;
      bit_counter  <= bit_counter_next;
      shift_byte   <= shift_byte_next;
      wait_counter <= wait_counter_next;
      scl_reg      <= scl_reg_next;
      sda_reg      <= sda_reg_next;
      drive_reg    <= drive_reg_next;
      timeout_flag <= timeout_flag_next;
      read_hold    <= read_hold_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (take) begin
      oq[owr_ptr] <= res;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ocount  <= 2'd0;
    end else begin
      if (take) begin
        owr_ptr <= !owr_ptr;
      end
      if (pop_ok) begin
        ord_ptr <= !ord_ptr;
      end
      ocount <= ocount + {1'b0, take} - {1'b0, pop_ok};
    end
  end

endmodule
